// File: rtl/fas_pkg.sv
package fas_pkg;

    localparam int unsigned MANT_BITS = 23;
    localparam logic [7:0]  EXP_MAX   = 8'hfe;

    // stage 1 -> stage 2: operands aligned, ready for add
    typedef struct packed {
        logic        far;
        logic [31:0] far_bits;
        logic        sa;
        logic        sb;
        logic [7:0]  e;
        logic [23:0] ma;
        logic [23:0] mb;
    } align_t;

    // stage 2 -> stage 3: raw magnitude sum
    typedef struct packed {
        logic        far;
        logic [31:0] far_bits;
        logic        s;
        logic [7:0]  e;
        logic [24:0] m;
    } sum_t;

    // stage 3 -> stage 4: carry handled, leading zero count known
    typedef struct packed {
        logic        done;
        logic [31:0] done_bits;
        logic        s;
        logic [7:0]  e;
        logic [23:0] m;
        logic [4:0]  lz;
    } norm_t;

endpackage

// File: rtl/float32_add_sub_truncating_core.sv
// single-precision add/subtract with truncation, no rounding and no special-value handling.
// four-stage pipeline (align, add, carry and leading-zero count, normalize shift), one
// request accepted per cycle unless stalled, each result passing in turn through the align,
// sum, norm and result registers; a stall at the output freezes every stage together.
module float32_add_sub_truncating_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sum_bits
);

    fas_pkg::align_t align_c;
    fas_pkg::align_t align_reg;
    fas_pkg::sum_t   sum_c;
    fas_pkg::sum_t   sum_reg;
    fas_pkg::norm_t  norm_c;
    fas_pkg::norm_t  norm_reg;
    logic [31:0]     res_c;
    logic [31:0]     res_reg;
    logic [3:0]      vld_reg;
    logic [3:0]      vld_next;
    logic            adv;

    fas_align  u_align  (.func(func), .operand_a(operand_a), .operand_b(operand_b),
                         .align(align_c));
    fas_addsub u_addsub (.align(align_reg), .sum(sum_c));
    fas_lzc    u_lzc    (.sum(sum_reg), .norm(norm_c));
    fas_shift  u_shift  (.norm(norm_reg), .sum_bits(res_c));

    assign adv       = !(vld_reg[3] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[3];
    assign sum_bits  = res_reg;
    assign vld_next  = {vld_reg[2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            align_reg <= align_c;
            sum_reg   <= sum_c;
            norm_reg  <= norm_c;
            res_reg   <= res_c;
        end
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sum_bits))
        else $error("stalled result changed");

    a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    a_pipe_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && in_valid |=> vld_reg[0])
        else $error("accepted request lost in first stage");

endmodule

// File: rtl/fas_align.sv
module fas_align (
    input  logic                 func,
    input  logic [31:0]          operand_a,
    input  logic [31:0]          operand_b,
    output fas_pkg::align_t      align
);

    logic [31:0] b;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [7:0]  diff;
    logic        a_big;
    logic [23:0] ma;
    logic [23:0] mb;

    always_comb
    begin
        b     = {operand_b[31] ^ func, operand_b[30:0]};
        ea    = operand_a[30:23];
        eb    = b[30:23];
        ma    = {1'b1, operand_a[22:0]};
        mb    = {1'b1, b[22:0]};
        a_big = ea > eb;
        diff  = a_big ? (ea - eb) : (eb - ea);
        align.far      = diff > 8'(fas_pkg::MANT_BITS);
        align.far_bits = a_big ? operand_a : b;
        align.sa       = operand_a[31];
        align.sb       = b[31];
        align.e        = a_big ? ea : eb;
        align.ma       = a_big ? ma : (ma >> diff[4:0]);
        align.mb       = a_big ? (mb >> diff[4:0]) : mb;
    end

endmodule

// File: rtl/fas_addsub.sv
module fas_addsub (
    input  fas_pkg::align_t align,
    output fas_pkg::sum_t   sum
);

    always_comb
    begin
        sum.far      = align.far;
        sum.far_bits = align.far_bits;
        sum.e        = align.e;
        if (align.sa == align.sb)
        begin
            sum.m = {1'b0, align.ma} + {1'b0, align.mb};
            sum.s = align.sa;
        end
        else if (align.ma > align.mb)
        begin
            sum.m = {1'b0, align.ma - align.mb};
            sum.s = align.sa;
        end
        else
        begin
            sum.m = {1'b0, align.mb - align.ma};
            sum.s = align.sb;
        end
    end

endmodule

// File: rtl/fas_lzc.sv
module fas_lzc (
    input  fas_pkg::sum_t  sum,
    output fas_pkg::norm_t norm
);

    logic [8:0]  e_inc;
    logic [23:0] m;
    logic [4:0]  lz;

    always_comb
    begin
        e_inc = {1'b0, sum.e} + 9'd1;
        m     = sum.m[24] ? sum.m[24:1] : sum.m[23:0];
        lz    = 5'd24;
        for (int i = 0; i < 24; i++)
        begin
            if (m[i])
            begin
                lz = 5'(23 - i);
            end
        end
        norm.s  = sum.s;
        norm.m  = m;
        norm.lz = lz;
        norm.e  = sum.m[24] ? e_inc[7:0] : sum.e;
        if (sum.far)
        begin
            norm.done      = 1'b1;
            norm.done_bits = sum.far_bits;
        end
        else if (sum.m == 25'd0)
        begin
            norm.done      = 1'b1;
            norm.done_bits = 32'd0;
        end
        else if (sum.m[24] && e_inc > {1'b0, fas_pkg::EXP_MAX})
        begin
            norm.done      = 1'b1;
            norm.done_bits = {sum.s, 8'hff, 23'd0};
        end
        else
        begin
            norm.done      = 1'b0;
            norm.done_bits = 32'd0;
        end
    end

endmodule

// File: rtl/fas_shift.sv
module fas_shift (
    input  fas_pkg::norm_t norm,
    output logic [31:0]    sum_bits
);

    logic [7:0]  sh;
    logic [23:0] m;

    always_comb
    begin
        // shift stops once the exponent would reach zero
        sh = ({3'd0, norm.lz} > norm.e) ? norm.e : {3'd0, norm.lz};
        m  = norm.m << sh[4:0];
        if (norm.done)
        begin
            sum_bits = norm.done_bits;
        end
        else
        begin
            sum_bits = {norm.s, norm.e - sh, m[22:0]};
        end
    end

endmodule
